/* design/stk_pkg.sv */
// Shared types, character constants and byte classifiers for the source tokenizer
`timescale 1ns / 1ps

package stk_pkg;

   // token kinds as they appear on the result channel
   typedef enum logic [3:0] {
      KIND_ID        = 4'd0,
      KIND_INT       = 4'd1,
      KIND_EQUALS    = 4'd2,
      KIND_ARROW     = 4'd3,
      KIND_LPAREN    = 4'd4,
      KIND_RPAREN    = 4'd5,
      KIND_LBRACE    = 4'd6,
      KIND_RBRACE    = 4'd7,
      KIND_COLON     = 4'd8,
      KIND_COMMA     = 4'd9,
      KIND_LT        = 4'd10,
      KIND_GT        = 4'd11,
      KIND_SEMICOLON = 4'd12,
      KIND_END       = 4'd13,
      KIND_ERROR     = 4'd14
   } kind_type;

   // scanner modes, one-hot
   typedef enum logic [4:0] {
      MODE_IDLE = 5'b00001,
      MODE_ID   = 5'b00010,
      MODE_INT  = 5'b00100,
      MODE_EQ   = 5'b01000,
      MODE_HALT = 5'b10000
   } mode_type;

   // character codes
   localparam logic [7:0] CH_NUL    = 8'd0;
   localparam logic [7:0] CH_TAB    = 8'd9;
   localparam logic [7:0] CH_LF     = 8'd10;
   localparam logic [7:0] CH_CR     = 8'd13;
   localparam logic [7:0] CH_SPACE  = 8'd32;
   localparam logic [7:0] CH_LPAREN = 8'd40;
   localparam logic [7:0] CH_RPAREN = 8'd41;
   localparam logic [7:0] CH_COMMA  = 8'd44;
   localparam logic [7:0] CH_ZERO   = 8'd48;
   localparam logic [7:0] CH_NINE   = 8'd57;
   localparam logic [7:0] CH_COLON  = 8'd58;
   localparam logic [7:0] CH_SEMI   = 8'd59;
   localparam logic [7:0] CH_LT     = 8'd60;
   localparam logic [7:0] CH_EQUALS = 8'd61;
   localparam logic [7:0] CH_GT     = 8'd62;
   localparam logic [7:0] CH_UPPER_A = 8'd65;
   localparam logic [7:0] CH_UPPER_Z = 8'd90;
   localparam logic [7:0] CH_LOWER_A = 8'd97;
   localparam logic [7:0] CH_LOWER_Z = 8'd122;
   localparam logic [7:0] CH_LBRACE = 8'd123;
   localparam logic [7:0] CH_RBRACE = 8'd125;

   localparam logic [7:0] LENGTH_MAX = 8'hFF;

   // result queue geometry
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = 2;
   localparam int QCNT_BITS   = 3;

   // one result beat
   typedef struct packed {
      kind_type    token_kind;
      logic [15:0] token_start;
      logic [7:0]  token_length;
      logic [7:0]  token_char;
      logic        last;
   } token_type;

   // tokens produced by one accepted byte, in order
   typedef struct packed {
      logic [1:0] count;
      token_type  first;
      token_type  second;
   } push_type;

   typedef struct packed {
      logic     hit;
      kind_type kind;
   } punct_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == CH_CR || c == CH_LF || c == CH_SPACE || c == CH_TAB;
   endfunction

   function automatic punct_type punct_lookup(input logic [7:0] c);
      punct_type p;
      p.hit = 1'b1;
      case (c)
         CH_LPAREN: p.kind = KIND_LPAREN;
         CH_RPAREN: p.kind = KIND_RPAREN;
         CH_LBRACE: p.kind = KIND_LBRACE;
         CH_RBRACE: p.kind = KIND_RBRACE;
         CH_COLON:  p.kind = KIND_COLON;
         CH_COMMA:  p.kind = KIND_COMMA;
         CH_LT:     p.kind = KIND_LT;
         CH_GT:     p.kind = KIND_GT;
         CH_SEMI:   p.kind = KIND_SEMICOLON;
         default: begin
            p.hit  = 1'b0;
            p.kind = KIND_ERROR;
         end
      endcase
      return p;
   endfunction

endpackage

/* design/stk_if.sv */
// Valid/ready channel interfaces for source bytes and tokens
`timescale 1ns / 1ps

interface stk_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

interface stk_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  token_kind;
   logic [15:0] token_start;
   logic [7:0]  token_length;
   logic [7:0]  token_char;
   logic        last;

   modport source (output valid, output token_kind, output token_start,
                   output token_length, output token_char, output last, input ready);
   modport sink   (input valid, input token_kind, input token_start,
                   input token_length, input token_char, input last, output ready);
endinterface

/* design/source_tokenizer.sv */
// Top level of the streaming source tokenizer
`timescale 1ns / 1ps

// Source tokenizer: takes one source byte per beat on req_chan and sends tokens
// (kind, start, length, byte, last) on rsp_chan. Each accepted byte is classified
// and the scan state updated in the same cycle, and its tokens are written into a
// four-entry result queue that sends one token per cycle while rsp_chan is ready.
// A byte is taken every cycle while the queue has at least two free entries, so
// the input runs at one byte per cycle as long as the output keeps up; a byte that
// both closes a run and gives a token of its own yields two tokens, and the
// one-token-per-cycle drain of the queue then sets the pace. After an error token
// the block takes bytes but gives no results until reset.
module source_tokenizer #(
   parameter int POSITION_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   stk_req_if.sink   req_chan,
   stk_rsp_if.source rsp_chan
);
   import stk_pkg::*;

   mode_type                 mode_ff, mode_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [15:0]              run_start_ff, run_start_in;
   logic [7:0]               run_len_ff, run_len_in;

   logic                     accept;
   logic                     room_ok;
   logic [7:0]               c;
   logic [15:0]              pos_low;
   logic [POSITION_BITS-1:0] pos_inc;
   punct_type                punct;
   logic                     cont;
   logic                     do_fresh;
   logic                     flush_v, fresh_v;
   token_type                flush_tok, fresh_tok;
   push_type                 push;

   assign c        = req_chan.char_code;
   assign accept   = req_chan.valid && req_chan.ready;
   assign req_chan.ready = room_ok;
   assign pos_low  = 16'(pos_ff);
   assign pos_inc  = pos_ff + POSITION_BITS'(1);
   assign punct    = punct_lookup(c);

   // scan step for one accepted byte
   always_comb begin
      mode_in      = mode_ff;
      pos_in       = pos_ff;
      run_start_in = run_start_ff;
      run_len_in   = run_len_ff;
      flush_v      = 1'b0;
      fresh_v      = 1'b0;
      flush_tok    = '0;
      fresh_tok    = '0;
      do_fresh     = 1'b0;
      cont         = (mode_ff == MODE_ID) ? is_letter(c) : is_digit(c);

      // close or extend whatever is open
      if (accept) begin
         case (mode_ff)
            MODE_ID, MODE_INT: begin
               if (cont) begin
                  if (run_len_ff != LENGTH_MAX) begin
                     run_len_in = run_len_ff + 8'd1;
                  end
                  pos_in = pos_inc;
               end else begin
                  flush_v                = 1'b1;
                  flush_tok.token_kind   = (mode_ff == MODE_ID) ? KIND_ID : KIND_INT;
                  flush_tok.token_start  = run_start_ff;
                  flush_tok.token_length = run_len_ff;
                  do_fresh               = 1'b1;
               end
            end
            MODE_EQ: begin
               flush_v               = 1'b1;
               flush_tok.token_start = run_start_ff;
               if (c == CH_GT) begin
                  flush_tok.token_kind   = KIND_ARROW;
                  flush_tok.token_length = 8'd2;
                  mode_in                = MODE_IDLE;
                  pos_in                 = pos_inc;
               end else begin
                  flush_tok.token_kind   = KIND_EQUALS;
                  flush_tok.token_length = 8'd1;
                  flush_tok.token_char   = CH_EQUALS;
                  do_fresh               = 1'b1;
               end
            end
            MODE_IDLE: do_fresh = 1'b1;
            default: ;
         endcase
      end

      // the byte on its own
      if (do_fresh) begin
         mode_in               = MODE_IDLE;
         pos_in                = pos_inc;
         fresh_tok.token_start = pos_low;
         if (c == CH_NUL) begin
            fresh_v              = 1'b1;
            fresh_tok.token_kind = KIND_END;
            pos_in               = '0;
         end else if (is_space(c)) begin
            fresh_v = 1'b0;
         end else if (is_letter(c) || is_digit(c) || c == CH_EQUALS) begin
            mode_in      = (c == CH_EQUALS) ? MODE_EQ : (is_letter(c) ? MODE_ID : MODE_INT);
            run_start_in = pos_low;
            run_len_in   = 8'd1;
         end else begin
            fresh_v                = 1'b1;
            fresh_tok.token_kind   = punct.hit ? punct.kind : KIND_ERROR;
            fresh_tok.token_length = 8'd1;
            fresh_tok.token_char   = c;
            if (!punct.hit) begin
               mode_in = MODE_HALT;
            end
         end
      end
   end

   // pack tokens in order and mark the final one
   always_comb begin
      push = '0;
      if (flush_v) begin
         push.first  = flush_tok;
         push.second = fresh_tok;
         push.count  = fresh_v ? 2'd2 : 2'd1;
         push.first.last  = !fresh_v;
         push.second.last = 1'b1;
      end else if (fresh_v) begin
         push.first      = fresh_tok;
         push.first.last = 1'b1;
         push.count      = 2'd1;
      end
   end

   // scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         pos_ff       <= '0;
         run_start_ff <= '0;
         run_len_ff   <= '0;
      end else begin
         mode_ff      <= mode_in;
         pos_ff       <= pos_in;
         run_start_ff <= run_start_in;
         run_len_ff   <= run_len_in;
      end
   end

   stk_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .room_ok  (room_ok),
      .rsp_chan (rsp_chan)
   );

   // halted scanner never produces tokens
   a_halt_quiet: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_HALT |-> push.count == 2'd0)
      else $error("tokens produced while halted");

   // halt holds until reset
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_HALT |=> mode_ff == MODE_HALT)
      else $error("left halt without reset");

   // end of source restarts the position count
   a_end_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && c == CH_NUL && mode_ff != MODE_HALT) |=> pos_ff == '0)
      else $error("position not restarted after end of source");

   // an open run or pending equals always has a nonzero length
   a_run_len: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_ID || mode_ff == MODE_INT || mode_ff == MODE_EQ) |-> run_len_ff != 8'd0)
      else $error("open run with zero length");

endmodule

/* design/stk_queue.sv */
// Four-entry token queue: takes up to two tokens per cycle, sends one per beat
`timescale 1ns / 1ps

module stk_queue (
   input  logic              clock,
   input  logic              reset,
   input  stk_pkg::push_type push,
   output logic              room_ok,
   stk_rsp_if.source         rsp_chan
);
   import stk_pkg::*;

   token_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   head_ff, head_in;
   logic [QPTR_BITS-1:0]   tail_ff, tail_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic [QPTR_BITS-1:0]   tail_next;
   logic                   pop;
   token_type              head_entry;

   // drain side
   assign pop        = (count_ff != '0) && rsp_chan.ready;
   assign head_entry = entry_ff[head_ff];
   assign tail_next  = tail_ff + QPTR_BITS'(1);

   // room for the worst case of two tokens from the next byte
   assign room_ok = count_ff <= QCNT_BITS'(QUEUE_DEPTH - 2);

   // pointer and fill updates
   assign head_in  = head_ff + QPTR_BITS'(pop);
   assign tail_in  = tail_ff + QPTR_BITS'(push.count);
   assign count_in = count_ff + QCNT_BITS'(push.count) - QCNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[tail_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[tail_next] <= push.second;
      end
   end

   // result channel
   assign rsp_chan.valid        = count_ff != '0;
   assign rsp_chan.token_kind   = head_entry.token_kind;
   assign rsp_chan.token_start  = head_entry.token_start;
   assign rsp_chan.token_length = head_entry.token_length;
   assign rsp_chan.token_char   = head_entry.token_char;
   assign rsp_chan.last         = head_entry.last;

endmodule

/* tb/source_tokenizer_test.sv */
// Self-checking testbench for the source tokenizer: random byte streams against a token predictor
`timescale 1ns / 1ps

module source_tokenizer_test;
   import stk_pkg::*;

   localparam int CYCLE_LIMIT      = 1_000_000;
   localparam int SETTLE_CYCLES    = 16;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int HOLD_AT_TOKEN    = 150;
   localparam int REPORT_LIMIT     = 10;
   localparam int RANDOM_BYTES     = 1050;
   localparam int HALTED_BYTES     = 20;

   // one source byte waiting to be offered
   typedef struct {
      logic [7:0] code;
      bit         wait_drain;
      bit         no_gap;
   } src_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   stk_req_if req_if ();
   stk_rsp_if rsp_if ();

   source_tokenizer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // clock generation
   always #6 clock = ~clock;

   src_byte_type pending_bytes[$];
   token_type    expected_tokens[$];

   // lexer shadow state
   mode_type    lex_mode  = MODE_IDLE;
   logic [15:0] lex_pos   = 16'd0;
   logic [15:0] lex_start = 16'd0;
   logic [7:0]  lex_len   = 8'd0;

   int          stim_items     = 0;
   int          bytes_sent     = 0;
   int          tokens_checked = 0;
   int          mismatch_count = 0;
   int          cycle_count;
   int          src_gap        = 0;
   int          sink_stall     = 0;
   int          sink_hold      = 0;
   bit          offer_live     = 1'b0;

   // byte classes
   function automatic bit letter_byte(input logic [7:0] c);
      return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
   endfunction

   function automatic bit digit_byte(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic bit blank_byte(input logic [7:0] c);
      return c == CH_CR || c == CH_LF || c == CH_SPACE || c == CH_TAB;
   endfunction

   function automatic bit punct_byte(input logic [7:0] c, output kind_type k);
      k = KIND_ERROR;
      punct_byte = 1'b1;
      case (c)
         CH_LPAREN: k = KIND_LPAREN;
         CH_RPAREN: k = KIND_RPAREN;
         CH_LBRACE: k = KIND_LBRACE;
         CH_RBRACE: k = KIND_RBRACE;
         CH_COLON:  k = KIND_COLON;
         CH_COMMA:  k = KIND_COMMA;
         CH_LT:     k = KIND_LT;
         CH_GT:     k = KIND_GT;
         CH_SEMI:   k = KIND_SEMICOLON;
         default:   punct_byte = 1'b0;
      endcase
   endfunction

   function automatic bit known_byte(input logic [7:0] c);
      kind_type k;
      return c == CH_NUL || c == CH_EQUALS || letter_byte(c) || digit_byte(c) ||
             blank_byte(c) || punct_byte(c, k);
   endfunction

   function automatic token_type token_of(input kind_type k, input logic [15:0] s,
                                          input logic [7:0] n, input logic [7:0] ch);
      token_type t;
      t.token_kind   = k;
      t.token_start  = s;
      t.token_length = n;
      t.token_char   = ch;
      t.last         = 1'b0;
      return t;
   endfunction

   // works out the tokens one accepted byte gives and queues them
   task automatic predict_tokens(input logic [7:0] c);
      token_type   toks[$];
      token_type   t;
      kind_type    pk;
      logic [15:0] here;
      bit          taken;
      here  = lex_pos;
      taken = 1'b0;
      if (lex_mode == MODE_HALT) return;
      lex_pos = here + 16'd1;

      // an open run either grows or is flushed
      if (lex_mode == MODE_ID || lex_mode == MODE_INT) begin
         if ((lex_mode == MODE_ID) ? letter_byte(c) : digit_byte(c)) begin
            if (lex_len != LENGTH_MAX) lex_len = lex_len + 8'd1;
            taken = 1'b1;
         end else begin
            toks.push_back(token_of(lex_mode == MODE_ID ? KIND_ID : KIND_INT,
                                    lex_start, lex_len, CH_NUL));
            lex_mode = MODE_IDLE;
         end
      end else if (lex_mode == MODE_EQ) begin
         // pending equals: arrow or plain equals
         lex_mode = MODE_IDLE;
         if (c == CH_GT) begin
            toks.push_back(token_of(KIND_ARROW, lex_start, 8'd2, CH_NUL));
            taken = 1'b1;
         end else begin
            toks.push_back(token_of(KIND_EQUALS, lex_start, 8'd1, CH_EQUALS));
         end
      end

      // the byte on its own
      if (!taken) begin
         if (c == CH_NUL) begin
            toks.push_back(token_of(KIND_END, here, 8'd0, CH_NUL));
            lex_pos = 16'd0;
         end else if (blank_byte(c)) begin
            // skipped
         end else if (letter_byte(c) || digit_byte(c)) begin
            lex_mode  = letter_byte(c) ? MODE_ID : MODE_INT;
            lex_start = here;
            lex_len   = 8'd1;
         end else if (c == CH_EQUALS) begin
            lex_mode  = MODE_EQ;
            lex_start = here;
            lex_len   = 8'd1;
         end else if (punct_byte(c, pk)) begin
            toks.push_back(token_of(pk, here, 8'd1, c));
         end else begin
            toks.push_back(token_of(KIND_ERROR, here, 8'd1, c));
            lex_mode = MODE_HALT;
         end
      end

      // flag the final token of this byte
      foreach (toks[i]) begin
         t      = toks[i];
         t.last = (i == toks.size() - 1);
         expected_tokens.push_back(t);
      end
   endtask

   // stimulus building
   task automatic add_byte(input logic [7:0] c, input bit fast = 1'b0, input bit drain = 1'b0);
      src_byte_type b;
      b.code       = c;
      b.no_gap     = fast;
      b.wait_drain = drain;
      pending_bytes.push_back(b);
      if (!fast) stim_items++;
   endtask

   function automatic logic [7:0] rand_letter();
      return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + 8'($urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] rand_digit();
      return CH_ZERO + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] rand_blank();
      case ($urandom_range(0, 3))
         0:       return CH_CR;
         1:       return CH_LF;
         2:       return CH_TAB;
         default: return CH_SPACE;
      endcase
   endfunction

   function automatic logic [7:0] rand_punct();
      case ($urandom_range(0, 8))
         0:       return CH_LPAREN;
         1:       return CH_RPAREN;
         2:       return CH_LBRACE;
         3:       return CH_RBRACE;
         4:       return CH_COLON;
         5:       return CH_COMMA;
         6:       return CH_LT;
         7:       return CH_GT;
         default: return CH_SEMI;
      endcase
   endfunction

   function automatic logic [7:0] rand_known();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 127)); while (!known_byte(c));
      return c;
   endfunction

   // source side: predict on each accepted beat, then offer the next byte
   always @(posedge clock) begin
      src_byte_type b;
      if (!reset && req_if.valid && req_if.ready) begin
         predict_tokens(req_if.char_code);
         bytes_sent++;
         offer_live = 1'b0;
      end
      @(negedge clock);
      if (!reset && !offer_live) begin
         if (src_gap > 0) begin
            src_gap--;
         end else if (pending_bytes.size() > 0 &&
                      !(pending_bytes[0].wait_drain && expected_tokens.size() != 0)) begin
            b = pending_bytes.pop_front();
            req_if.char_code <= b.code;
            offer_live = 1'b1;
            src_gap = (b.no_gap || (bytes_sent % 256) >= 192) ? 0 : $urandom_range(0, 9);
         end
      end
      req_if.valid <= offer_live;
   end

   // token side: check each accepted beat, then decide on ready
   always @(posedge clock) begin
      token_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_tokens.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected token: kind %0d start %0d length %0d char %0d last %0b",
                        rsp_if.token_kind, rsp_if.token_start, rsp_if.token_length,
                        rsp_if.token_char, rsp_if.last);
         end else begin
            want = expected_tokens.pop_front();
            if (rsp_if.token_kind !== want.token_kind || rsp_if.token_start !== want.token_start ||
                rsp_if.token_length !== want.token_length ||
                rsp_if.token_char !== want.token_char || rsp_if.last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("token %0d: expected %0d/%0d/%0d/%0d/%0b got %0d/%0d/%0d/%0d/%0b",
                           tokens_checked, want.token_kind, want.token_start,
                           want.token_length, want.token_char, want.last,
                           rsp_if.token_kind, rsp_if.token_start, rsp_if.token_length,
                           rsp_if.token_char, rsp_if.last);
            end
         end
         tokens_checked++;
         sink_stall = ((tokens_checked % 128) < 32) ? 0 : $urandom_range(0, 9);
         if (tokens_checked == HOLD_AT_TOKEN) sink_hold = LONG_HOLD_CYCLES;
      end
      @(negedge clock);
      if (sink_hold > 0) begin
         sink_hold--;
         rsp_if.ready <= 1'b0;
      end else if (sink_stall > 0) begin
         sink_stall--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
   end

   // stimulus and end of run
   initial begin
      string      directed_text;
      logic [7:0] c;
      bit         long_id_done;
      bit         long_int_done;
      bit         drain_done;
      int         n;

      long_id_done     = 1'b0;
      long_int_done    = 1'b0;
      drain_done       = 1'b0;

      // directed: letter and digit extremes, every punctuator, blanks,
      // equals flushed by equals, arrow, equals flushed by a punctuator,
      // runs flushed by a punctuator and by end of source
      directed_text = "AZaz09(){}:,<>; \t\015\n==>=(9";
      for (int i = 0; i < directed_text.len(); i++) add_byte(directed_text[i]);
      add_byte(CH_NUL);

      // random: mostly well-formed pieces, some loose bytes
      stim_items = 0;
      while (stim_items < RANDOM_BYTES) begin
         if (!long_id_done && stim_items >= 200) begin
            // identifier that saturates its length
            for (int i = 0; i < 257; i++) add_byte(rand_letter());
            add_byte(rand_punct());
            long_id_done = 1'b1;
         end else if (!drain_done && stim_items >= 400) begin
            add_byte(rand_letter(), 1'b0, 1'b1);
            drain_done = 1'b1;
         end else if (!long_int_done && stim_items >= 700) begin
            for (int i = 0; i < 256; i++) add_byte(rand_digit());
            add_byte(CH_NUL);
            long_int_done = 1'b1;
         end else begin
            case ($urandom_range(0, 9))
               0, 1: begin
                  n = $urandom_range(1, 12);
                  repeat (n) add_byte(rand_letter());
               end
               2: begin
                  n = $urandom_range(1, 8);
                  repeat (n) add_byte(rand_digit());
               end
               3, 4: add_byte(rand_punct());
               5: begin
                  n = $urandom_range(1, 3);
                  repeat (n) add_byte(rand_blank());
               end
               6: begin
                  add_byte(CH_EQUALS);
                  if ($urandom_range(0, 1)) add_byte(CH_GT);
               end
               7: add_byte(($urandom_range(0, 5) == 0) ? CH_NUL : rand_blank());
               default: begin
                  n = $urandom_range(1, 4);
                  repeat (n) add_byte(rand_known());
               end
            endcase
         end
      end

      // unexpected byte halts the block; later bytes give nothing
      do c = 8'($urandom_range(1, 255)); while (known_byte(c));
      add_byte(c);
      repeat (HALTED_BYTES) add_byte(8'($urandom_range(0, 255)));

      // reset, released on a falling edge
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || req_if.valid) @(posedge clock);
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("sent %0d source bytes, checked %0d tokens, %0d mismatches", bytes_sent,
               tokens_checked, mismatch_count);
      $display("stream had saturated runs, a full drain, stalls both ways and a final halt");
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
